>>> rtl/core/igps_pkg.sv
// package for the idle gated persistence scheduler
// word types, request and phase codes, register indexes and reset values
// no dependencies
package igps_pkg;

  localparam int unsigned RegWidth = 16;
  localparam int unsigned RegIdxWidth = 2;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_WRITE_ALL = 3'd1,
    REQ_SETTINGS  = 3'd2,
    REQ_READ_FAIL = 3'd3,
    REQ_REARM     = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    PH_WATCH = 2'd0,
    PH_WAIT  = 2'd1,
    PH_SAVE  = 2'd2
  } save_phase_e;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_HOLDOFF    = 2'd0,
    REG_SAVE_DELAY = 2'd1,
    REG_WRITE_ALL  = 2'd2,
    REG_SETTINGS   = 2'd3
  } reg_idx_e;

  localparam logic [RegWidth-1:0] HoldoffReset   = 16'd5000;
  localparam logic [RegWidth-1:0] SaveDelayReset = 16'd500;
  localparam logic [RegWidth-1:0] WriteAllReset  = 16'd100;
  localparam logic [RegWidth-1:0] SettingsReset  = 16'd1000;

  typedef struct packed {
    logic [2:0] req_type;
    logic       raw_busy;
    logic       fail_item;
    logic       fail_load;
  } in_word_t;

  typedef struct packed {
    logic save_position;
    logic write_all;
    logic write_settings;
    logic alarm_master;
    logic alarm_backup;
    logic qualified_busy;
  } out_word_t;

endpackage

>>> rtl/core/idle_gated_persist_scheduler_core.sv
// top level of the idle gated persistence scheduler
// uses igps_pkg and igps_pend_cnt
//
// usage:
//   input channel in_valid_i / in_stall_o / in_word_i carries one request word:
//   a tick with the raw busy bit, a write-all or settings request, a read
//   failure report or an alarm rearm. every input word produces exactly one
//   output word on out_valid_o / out_stall_i / out_word_o with the save,
//   write and alarm pulses and the qualified busy status.
//   the result is registered: it enters the output register at the
//   accepting edge. one word is accepted every cycle while the input is
//   not stalled; the state update is a single pass of counters and compares
//   ahead of the output register.
//   when the receiver stalls, the output word holds and the input stalls
//   only while the output register is full and stalled.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (hold-off, save delay, write-all threshold, settings threshold); write
//   only while no word is in flight.
//   reset: registers take their default values, state returns to watching
//   with busy assumed, alarms armed, nothing pending, output empty.
module idle_gated_persist_scheduler_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [igps_pkg::RegIdxWidth-1:0] cfg_idx_i,
  input  logic [igps_pkg::RegWidth-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  igps_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output igps_pkg::out_word_t              out_word_o
);

  localparam int unsigned CmpWidth =
    (COUNT_WIDTH > igps_pkg::RegWidth) ? COUNT_WIDTH : igps_pkg::RegWidth;
  localparam logic [CmpWidth-1:0] CmaxExt = CmpWidth'({COUNT_WIDTH{1'b1}});

  logic [igps_pkg::RegWidth-1:0] holdoff_reg_q, save_delay_reg_q;
  logic [igps_pkg::RegWidth-1:0] write_all_reg_q, settings_reg_q;

  igps_pkg::save_phase_e  phase_q, phase_d;
  logic                   prev_busy_q, prev_busy_d;
  logic [COUNT_WIDTH-1:0] holdoff_q, holdoff_d;
  logic [COUNT_WIDTH-1:0] save_left_q, save_left_d;
  logic                   master_err_q, master_err_d;
  logic                   backup_err_q, backup_err_d;
  logic                   master_armed_q, master_armed_d;
  logic                   backup_armed_q, backup_armed_d;

  logic                   out_valid_q, out_valid_d;
  igps_pkg::out_word_t    out_word_q, out_word_d;

  logic                   accept;
  logic                   is_tick;
  logic                   busy;
  logic                   idle_tick;
  logic [COUNT_WIDTH-1:0] holdoff_dec, save_dec;
  logic [COUNT_WIDTH-1:0] holdoff_load, save_load;
  logic [CmpWidth-1:0]    holdoff_ext, save_ext;
  logic                   fire_all, fire_set;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_tick    = (in_word_i.req_type == igps_pkg::REQ_TICK);

  // saturated register loads and counter decrements that stop at zero
  always_comb begin
    holdoff_ext  = CmpWidth'(holdoff_reg_q);
    save_ext     = CmpWidth'(save_delay_reg_q);
    holdoff_load = (holdoff_ext > CmaxExt) ? {COUNT_WIDTH{1'b1}} : holdoff_ext[COUNT_WIDTH-1:0];
    save_load    = (save_ext > CmaxExt) ? {COUNT_WIDTH{1'b1}} : save_ext[COUNT_WIDTH-1:0];
    holdoff_dec  = (holdoff_q != '0) ? holdoff_q - COUNT_WIDTH'(1) : holdoff_q;
    save_dec     = (save_left_q != '0) ? save_left_q - COUNT_WIDTH'(1) : save_left_q;
  end

  always_comb begin
    phase_d        = phase_q;
    prev_busy_d    = prev_busy_q;
    holdoff_d      = holdoff_q;
    save_left_d    = save_left_q;
    master_err_d   = master_err_q;
    backup_err_d   = backup_err_q;
    master_armed_d = master_armed_q;
    backup_armed_d = backup_armed_q;
    out_word_d     = '0;

    if (is_tick) begin
      holdoff_d   = in_word_i.raw_busy ? holdoff_load : holdoff_dec;
      save_left_d = save_dec;
      busy        = in_word_i.raw_busy || (holdoff_d != '0);
      unique case (phase_q)
        igps_pkg::PH_WATCH: begin
          if (prev_busy_q && !busy) begin
            phase_d     = igps_pkg::PH_WAIT;
            save_left_d = save_load;
          end
          prev_busy_d = busy;
        end
        igps_pkg::PH_WAIT: begin
          if (busy) begin
            phase_d = igps_pkg::PH_WATCH;
          end else if (save_dec == '0) begin
            phase_d = igps_pkg::PH_SAVE;
          end
        end
        igps_pkg::PH_SAVE: begin
          phase_d                  = igps_pkg::PH_WATCH;
          out_word_d.save_position = 1'b1;
        end
        default: begin
          phase_d = igps_pkg::PH_WATCH;
        end
      endcase
    end else begin
      busy = (holdoff_q != '0);
      if (in_word_i.req_type == igps_pkg::REQ_READ_FAIL) begin
        if (!in_word_i.fail_item) begin
          master_err_d = 1'b1;
        end else if (in_word_i.fail_load) begin
          backup_err_d = 1'b1;
        end
      end
      if (in_word_i.req_type == igps_pkg::REQ_REARM) begin
        master_armed_d = 1'b1;
        backup_armed_d = 1'b1;
      end
    end

    if (master_err_d && master_armed_d) begin
      master_armed_d          = 1'b0;
      out_word_d.alarm_master = 1'b1;
    end
    if (master_err_d && backup_err_d && backup_armed_d) begin
      backup_armed_d          = 1'b0;
      out_word_d.alarm_backup = 1'b1;
    end

    out_word_d.write_all      = fire_all;
    out_word_d.write_settings = fire_set;
    out_word_d.qualified_busy = busy;
  end

  assign idle_tick = accept && is_tick && !busy;

  igps_pend_cnt #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_all_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (accept && (in_word_i.req_type == igps_pkg::REQ_WRITE_ALL)),
    .idle_tick_i(idle_tick),
    .thresh_i   (write_all_reg_q),
    .fire_o     (fire_all)
  );

  igps_pend_cnt #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_set_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (accept && (in_word_i.req_type == igps_pkg::REQ_SETTINGS)),
    .idle_tick_i(idle_tick),
    .thresh_i   (settings_reg_q),
    .fire_o     (fire_set)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_reg_q    <= igps_pkg::HoldoffReset;
      save_delay_reg_q <= igps_pkg::SaveDelayReset;
      write_all_reg_q  <= igps_pkg::WriteAllReset;
      settings_reg_q   <= igps_pkg::SettingsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        igps_pkg::REG_HOLDOFF:    holdoff_reg_q    <= cfg_data_i;
        igps_pkg::REG_SAVE_DELAY: save_delay_reg_q <= cfg_data_i;
        igps_pkg::REG_WRITE_ALL:  write_all_reg_q  <= cfg_data_i;
        igps_pkg::REG_SETTINGS:   settings_reg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= igps_pkg::PH_WATCH;
      prev_busy_q    <= 1'b1;
      holdoff_q      <= '0;
      save_left_q    <= '0;
      master_err_q   <= 1'b0;
      backup_err_q   <= 1'b0;
      master_armed_q <= 1'b1;
      backup_armed_q <= 1'b1;
    end else if (accept) begin
      phase_q        <= phase_d;
      prev_busy_q    <= prev_busy_d;
      holdoff_q      <= holdoff_d;
      save_left_q    <= save_left_d;
      master_err_q   <= master_err_d;
      backup_err_q   <= backup_err_d;
      master_armed_q <= master_armed_d;
      backup_armed_q <= backup_armed_d;
    end
  end

  // output register
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/core/igps_pend_cnt.sv
// pending request counter: counts idle ticks and fires once at threshold
// uses igps_pkg for the register width
module igps_pend_cnt #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic                          idle_tick_i,
  input  logic [igps_pkg::RegWidth-1:0] thresh_i,
  output logic                          fire_o
);

  localparam int unsigned CmpWidth =
    (COUNT_WIDTH > igps_pkg::RegWidth) ? COUNT_WIDTH : igps_pkg::RegWidth;

  logic                   pending_q, pending_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_comb begin
    count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + COUNT_WIDTH'(1);
    fire_o    = pending_q && idle_tick_i &&
                (CmpWidth'(count_inc) >= CmpWidth'(thresh_i));
    pending_d = pending_q;
    count_d   = count_q;
    if (req_i) begin
      pending_d = 1'b1;
    end
    if (pending_q && idle_tick_i) begin
      if (fire_o) begin
        count_d   = '0;
        pending_d = 1'b0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      count_q   <= '0;
    end else begin
      pending_q <= pending_d;
      count_q   <= count_d;
    end
  end

endmodule

>>> tb/igps_pulse_checker.sv
// predicts every output word of the idle gated persistence scheduler and
// compares it field by field with the word the block hands out
// depends on igps_pkg; watches the channels and the configuration port only
module igps_pulse_checker #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [igps_pkg::RegIdxWidth-1:0] cfg_idx_i,
  input  logic [igps_pkg::RegWidth-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  igps_pkg::in_word_t               in_word_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  igps_pkg::out_word_t              out_word_i,
  output int unsigned                      due_count_o,
  output int unsigned                      error_count_o
);

  logic [igps_pkg::RegWidth-1:0] holdoff_ticks, save_delay_ticks;
  logic [igps_pkg::RegWidth-1:0] write_all_ticks, settings_ticks;

  igps_pkg::save_phase_e  phase;
  logic                   last_busy;
  logic [COUNT_WIDTH-1:0] holdoff_left, save_left, all_count, settings_count;
  logic                   all_pending, settings_pending;
  logic                   master_err, backup_err, master_armed, backup_armed;

  igps_pkg::out_word_t due_words[$];
  igps_pkg::out_word_t predicted, wanted;
  int unsigned         fails;
  string               field_names[6] = '{"save_position", "write_all", "write_settings",
                                          "alarm_master", "alarm_backup", "qualified_busy"};

  function automatic logic [COUNT_WIDTH-1:0] clamp_load(logic [igps_pkg::RegWidth-1:0] v);
    if ((32'(v) >> COUNT_WIDTH) != 0) return '1;
    return COUNT_WIDTH'(v);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic schedule_word(input igps_pkg::in_word_t w, output igps_pkg::out_word_t r);
    logic busy;
    r = '0;
    if (w.req_type == igps_pkg::REQ_TICK) begin
      if (holdoff_left != '0) holdoff_left = holdoff_left - 1'b1;
      if (save_left != '0) save_left = save_left - 1'b1;
      if (w.raw_busy) holdoff_left = clamp_load(holdoff_ticks);
      busy = w.raw_busy || (holdoff_left != '0);
      case (phase)
        igps_pkg::PH_WATCH: begin
          if (last_busy && !busy) begin
            phase = igps_pkg::PH_WAIT;
            save_left = clamp_load(save_delay_ticks);
          end
          last_busy = busy;
        end
        igps_pkg::PH_WAIT: begin
          if (busy) phase = igps_pkg::PH_WATCH;
          else if (save_left == '0) phase = igps_pkg::PH_SAVE;
        end
        igps_pkg::PH_SAVE: begin
          phase = igps_pkg::PH_WATCH;
          r.save_position = 1'b1;
        end
        default: phase = igps_pkg::PH_WATCH;
      endcase
      if (all_pending && !busy) begin
        all_count = bump(all_count);
        if (all_count >= write_all_ticks) begin
          all_count = '0;
          all_pending = 1'b0;
          r.write_all = 1'b1;
        end
      end
      if (settings_pending && !busy) begin
        settings_count = bump(settings_count);
        if (settings_count >= settings_ticks) begin
          settings_count = '0;
          settings_pending = 1'b0;
          r.write_settings = 1'b1;
        end
      end
    end else begin
      case (w.req_type)
        igps_pkg::REQ_WRITE_ALL: all_pending = 1'b1;
        igps_pkg::REQ_SETTINGS: settings_pending = 1'b1;
        igps_pkg::REQ_READ_FAIL: begin
          if (!w.fail_item) master_err = 1'b1;
          else if (w.fail_load) backup_err = 1'b1;
        end
        igps_pkg::REQ_REARM: begin
          master_armed = 1'b1;
          backup_armed = 1'b1;
        end
        default: ;
      endcase
      busy = holdoff_left != '0;
    end
    if (master_err && master_armed) begin
      master_armed = 1'b0;
      r.alarm_master = 1'b1;
    end
    if (master_err && backup_err && backup_armed) begin
      backup_armed = 1'b0;
      r.alarm_backup = 1'b1;
    end
    r.qualified_busy = busy;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_ticks = igps_pkg::HoldoffReset;
      save_delay_ticks = igps_pkg::SaveDelayReset;
      write_all_ticks = igps_pkg::WriteAllReset;
      settings_ticks = igps_pkg::SettingsReset;
      phase = igps_pkg::PH_WATCH;
      last_busy = 1'b1;
      holdoff_left = '0;
      save_left = '0;
      all_pending = 1'b0;
      all_count = '0;
      settings_pending = 1'b0;
      settings_count = '0;
      master_err = 1'b0;
      backup_err = 1'b0;
      master_armed = 1'b1;
      backup_armed = 1'b1;
      due_words.delete();
      fails = 0;
      due_count_o <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          igps_pkg::REG_HOLDOFF: holdoff_ticks = cfg_data_i;
          igps_pkg::REG_SAVE_DELAY: save_delay_ticks = cfg_data_i;
          igps_pkg::REG_WRITE_ALL: write_all_ticks = cfg_data_i;
          igps_pkg::REG_SETTINGS: settings_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        schedule_word(in_word_i, predicted);
        due_words.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: word with none due, expected none actual %b", $time, out_word_i);
          fails++;
        end else begin
          wanted = due_words.pop_front();
          for (int b = 5; b >= 0; b--) begin
            if (out_word_i[b] !== wanted[b]) begin
              $display("%0t: %s expected %b actual %b", $time, field_names[5-b],
                       wanted[b], out_word_i[b]);
              fails++;
            end
          end
        end
      end
      due_count_o <= due_words.size();
      error_count_o <= fails;
    end
  end

endmodule

>>> tb/tb_idle_gated_persist_scheduler_core.sv
// testbench top for idle_gated_persist_scheduler_core: directed and random
// request words through several register settings, with random gaps and stalls
// depends on igps_pkg, the block and igps_pulse_checker
module tb_idle_gated_persist_scheduler_core;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [2:0] ReqUnknownLo = 3'd5;
  localparam logic [2:0] ReqUnknownHi = 3'd7;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [igps_pkg::RegIdxWidth-1:0] cfg_idx = '0;
  logic [igps_pkg::RegWidth-1:0]    cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  igps_pkg::in_word_t               in_word = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  igps_pkg::out_word_t              out_word;

  int unsigned due_count, error_count;
  int unsigned cycle = 0;
  int unsigned sent_count = 0;
  int unsigned stall_left = 0;
  bit          held_long = 1'b0;
  logic        quiet;

  assign quiet = ((cycle / 700) % 3) == 0;

  idle_gated_persist_scheduler_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  igps_pulse_checker pulse_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .due_count_o   (due_count),
    .error_count_o (error_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("idle_gated_persist_scheduler_core: mismatch");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, one long hold so the block backs up into its input
  always @(posedge clk) begin
    if (!held_long && sent_count >= 300) begin
      held_long <= 1'b1;
      stall_left <= 200;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic igps_pkg::in_word_t mk(logic [2:0] req, logic raw, logic item,
                                            logic load);
    igps_pkg::in_word_t w;
    w.req_type = req;
    w.raw_busy = raw;
    w.fail_item = item;
    w.fail_load = load;
    return w;
  endfunction

  function automatic igps_pkg::in_word_t tick_word(logic raw);
    return mk(igps_pkg::REQ_TICK, raw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic igps_pkg::in_word_t request_word();
    int unsigned r;
    logic [2:0]  req;
    r = $urandom_range(0, 99);
    if (r < 30) req = igps_pkg::REQ_WRITE_ALL;
    else if (r < 60) req = igps_pkg::REQ_SETTINGS;
    else if (r < 75) req = igps_pkg::REQ_READ_FAIL;
    else if (r < 90) req = igps_pkg::REQ_REARM;
    else req = 3'($urandom_range(ReqUnknownLo, ReqUnknownHi));
    return mk(req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endfunction

  task automatic send_word(input igps_pkg::in_word_t w);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sent_count <= sent_count + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input logic [igps_pkg::RegWidth-1:0] holdoff, save_delay,
                               write_all, settings);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= igps_pkg::REG_HOLDOFF;
    cfg_data <= holdoff;
    @(posedge clk);
    cfg_idx <= igps_pkg::REG_SAVE_DELAY;
    cfg_data <= save_delay;
    @(posedge clk);
    cfg_idx <= igps_pkg::REG_WRITE_ALL;
    cfg_data <= write_all;
    @(posedge clk);
    cfg_idx <= igps_pkg::REG_SETTINGS;
    cfg_data <= settings;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a busy stretch then an idle stretch, with requests sprinkled in
  task automatic run_episode(input int unsigned idle_cap);
    int unsigned busy_len, idle_len;
    bit          noisy;
    logic        raw;
    busy_len = $urandom_range(0, 4);
    idle_len = $urandom_range(1, idle_cap);
    noisy = $urandom_range(0, 99) < 15;
    for (int i = 0; i < busy_len + idle_len; i++) begin
      if ($urandom_range(0, 99) < 8) send_word(request_word());
      if (noisy) raw = 1'($urandom_range(0, 1));
      else if (i < busy_len) raw = $urandom_range(0, 5) != 0;
      else raw = 1'b0;
      send_word(tick_word(raw));
    end
  endtask

  task automatic run_phase(input int unsigned holdoff, save_delay, write_all, settings,
                           input int unsigned n);
    int unsigned target, cap, longest;
    set_registers(holdoff[15:0], save_delay[15:0], write_all[15:0], settings[15:0]);
    longest = (write_all > settings) ? write_all : settings;
    cap = holdoff + save_delay + longest + 6;
    if (cap > 48) cap = 48;
    target = sent_count + n;
    while (sent_count < target) run_episode(cap);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, no busy ticks so the long default hold-off never loads
    send_word(mk(igps_pkg::REQ_TICK, 1'b0, 1'b1, 1'b1));
    send_word(mk(igps_pkg::REQ_REARM, 1'b1, 1'b0, 1'b0));
    send_word(mk(ReqUnknownHi, 1'b1, 1'b1, 1'b1));
    send_word(mk(ReqUnknownLo, 1'b0, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_READ_FAIL, 1'b1, 1'b1, 1'b0));
    send_word(mk(igps_pkg::REQ_READ_FAIL, 1'b0, 1'b1, 1'b1));
    send_word(mk(igps_pkg::REQ_REARM, 1'b0, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_WRITE_ALL, 1'b1, 1'b1, 1'b1));
    send_word(mk(igps_pkg::REQ_SETTINGS, 1'b0, 1'b1, 1'b0));
    send_word(mk(igps_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_READ_FAIL, 1'b0, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_READ_FAIL, 1'b1, 1'b0, 1'b1));
    send_word(mk(igps_pkg::REQ_REARM, 1'b1, 1'b1, 1'b1));
    send_word(mk(igps_pkg::REQ_TICK, 1'b0, 1'b1, 1'b0));

    // small nonzero settings with a busy edge, requests and idle ticks
    set_registers(16'd2, 16'd3, 16'd2, 16'd4);
    send_word(mk(igps_pkg::REQ_TICK, 1'b1, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_WRITE_ALL, 1'b0, 1'b0, 1'b0));
    send_word(mk(igps_pkg::REQ_SETTINGS, 1'b0, 1'b0, 1'b0));
    repeat (10) send_word(tick_word(1'b0));

    run_phase(3, 4, 2, 5, 150);
    run_phase(0, 0, 0, 0, 150);
    run_phase(1, 1, 1, 1, 150);
    run_phase($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 12),
              $urandom_range(0, 16), 150);
    run_phase($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 12),
              $urandom_range(0, 16), 150);
    run_phase($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 12),
              $urandom_range(0, 16), 100);
    run_phase(0, 65535, 0, 65535, 100);
    run_phase(65535, 65535, 65535, 65535, 80);

    drain();
    if (error_count == 0 && due_count == 0) begin
      $display("idle_gated_persist_scheduler_core: match");
    end else begin
      $display("idle_gated_persist_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
